>>> sv/oal_pkg.sv
package oal_pkg;

   localparam int CAPACITY    = 64;
   localparam int ENTRY_WIDTH = 64;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int POS_W       = 7;
   localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int GRP         = 8;
   localparam int NGRP        = (CAPACITY + GRP - 1) / GRP;

   typedef enum logic [3:0] {
      CMD_INS_FRONT = 4'd0,
      CMD_INS_END   = 4'd1,
      CMD_INS_AT    = 4'd2,
      CMD_GET_FIRST = 4'd3,
      CMD_GET_LAST  = 4'd4,
      CMD_GET_AT    = 4'd5,
      CMD_REM_FIRST = 4'd6,
      CMD_REM_LAST  = 4'd7,
      CMD_REM_AT    = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_BADPOS   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [IDX_W-1:0]         target;
      logic [ENTRY_WIDTH-1:0]   word;
   } cell_ctl_type;

endpackage

>>> sv/ordered_array_list_top.sv
// ordered array list: a bounded ordered list of 64-bit entry words
// req channel: one command word (command, position, entry_word), valid/ready
// rsp channel: one result word per command (status, read_word, entry_count,
//   is_empty, is_full), valid/ready
// the entries sit in a row of cells; an insert shifts the cells above the
//   target up by one, a remove shifts them down by one, all in the same cycle
// a read is a one-hot pick across the cells, or-reduced through a registered
//   tree of eight-cell groups
// after the command word is taken, the controller passes through its execute
//   and gather states, and rsp_valid is high in the respond state
// a new command is taken only after the last one has gone through the
//   execute / gather / respond sequence of the controller
// req_ready is high only while no command is in flight
// a stalled rsp word holds until taken, and no new command is accepted
// reset empties the list at once; entry contents are not cleared
module ordered_array_list_top
   import oal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_command,
   input  logic [6:0]  req_position,
   input  logic [63:0] req_entry_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_read_word,
   output logic [6:0]  rsp_entry_count,
   output logic        rsp_is_empty,
   output logic        rsp_is_full
);

   cell_ctl_type           cell_ctl;
   logic [ENTRY_WIDTH-1:0] cell_data [CAPACITY];
   logic [ENTRY_WIDTH-1:0] cell_read [CAPACITY];
   logic [ENTRY_WIDTH-1:0] grp_ff    [NGRP];
   logic [ENTRY_WIDTH-1:0] grp_in    [NGRP];
   logic [ENTRY_WIDTH-1:0] gather_word;

   oal_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_entry_word  (req_entry_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_word   (rsp_read_word),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .gather_word     (gather_word),
      .cell_ctl        (cell_ctl)
   );

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] lower, upper;
      if (k == 0) begin : g_first
         assign lower = cell_data[k];
      end else begin : g_mid
         assign lower = cell_data[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign upper = cell_data[k];
      end else begin : g_low
         assign upper = cell_data[k+1];
      end
      oal_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .cell_index (IDX_W'(k)),
         .lower_data (lower),
         .upper_data (upper),
         .data       (cell_data[k]),
         .read_data  (cell_read[k])
      );
   end

   // group-wise or of the picked cell
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int m = 0; m < GRP; m++) begin
            if (g * GRP + m < CAPACITY) begin
               grp_in[g] = grp_in[g] | cell_read[g * GRP + m];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   always_comb begin
      gather_word = '0;
      for (int g = 0; g < NGRP; g++) begin
         gather_word = gather_word | grp_ff[g];
      end
   end

endmodule

>>> sv/oal_cell.sv
module oal_cell
   import oal_pkg::*;
(
   input  logic                   clock,
   input  cell_ctl_type           ctl,
   input  logic [IDX_W-1:0]       cell_index,
   input  logic [ENTRY_WIDTH-1:0] lower_data,
   input  logic [ENTRY_WIDTH-1:0] upper_data,
   output logic [ENTRY_WIDTH-1:0] data,
   output logic [ENTRY_WIDTH-1:0] read_data
);

   logic [ENTRY_WIDTH-1:0] data_ff;
   logic [ENTRY_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (cell_index > ctl.target) begin
               data_in = lower_data;
            end else if (cell_index == ctl.target) begin
               data_in = ctl.word;
            end
         end
         OP_REMOVE: begin
            if (cell_index >= ctl.target) begin
               data_in = upper_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign read_data = (ctl.op == OP_READ && cell_index == ctl.target) ? data_ff : '0;

endmodule

>>> sv/oal_ctrl.sv
module oal_ctrl
   import oal_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [3:0]             req_command,
   input  logic [6:0]             req_position,
   input  logic [63:0]            req_entry_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [63:0]            rsp_read_word,
   output logic [6:0]             rsp_entry_count,
   output logic                   rsp_is_empty,
   output logic                   rsp_is_full,
   input  logic [ENTRY_WIDTH-1:0] gather_word,
   output cell_ctl_type           cell_ctl
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_GATHER = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   status_type           status_ff, status_in;
   cell_ctl_type         ctl_ff, ctl_in;
   logic [63:0]          read_word_ff;
   logic [CMP_W-1:0]     pos_x, used_x;
   logic                 full, empty, accept;

   assign accept = req_valid && req_ready;
   assign pos_x  = CMP_W'(req_position);
   assign used_x = CMP_W'(used_ff);
   assign full   = (used_ff == CNT_W'(CAPACITY));
   assign empty  = (used_ff == '0);

   always_comb begin
      used_in     = used_ff;
      status_in   = ST_OK;
      ctl_in.op     = OP_NONE;
      ctl_in.target = '0;
      ctl_in.word   = ENTRY_WIDTH'(req_entry_word);
      unique case (req_command) inside
         CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (req_command == CMD_INS_AT && pos_x > used_x) begin
               status_in = ST_BADPOS;
            end else begin
               ctl_in.op = OP_INSERT;
               used_in   = used_ff + 1'b1;
               if (req_command == CMD_INS_END) begin
                  ctl_in.target = IDX_W'(used_ff);
               end else if (req_command == CMD_INS_AT) begin
                  ctl_in.target = IDX_W'(req_position);
               end
            end
         end
         CMD_GET_FIRST, CMD_GET_LAST, CMD_GET_AT,
         CMD_REM_FIRST, CMD_REM_LAST, CMD_REM_AT: begin
            if (empty) begin
               status_in = ST_NOTFOUND;
            end else if ((req_command == CMD_GET_AT || req_command == CMD_REM_AT)
                         && pos_x >= used_x) begin
               status_in = ST_NOTFOUND;
            end else begin
               if (req_command == CMD_GET_FIRST || req_command == CMD_GET_LAST ||
                   req_command == CMD_GET_AT) begin
                  ctl_in.op = OP_READ;
               end else begin
                  ctl_in.op = OP_REMOVE;
                  used_in   = used_ff - 1'b1;
               end
               if (req_command == CMD_GET_LAST || req_command == CMD_REM_LAST) begin
                  ctl_in.target = IDX_W'(used_ff - 1'b1);
               end else if (req_command == CMD_GET_AT || req_command == CMD_REM_AT) begin
                  ctl_in.target = IDX_W'(req_position);
               end
            end
         end
         default: status_in = ST_NOTFOUND;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_EXEC;
         S_EXEC:   state_in = S_GATHER;
         S_GATHER: state_in = S_RESP;
         S_RESP:   if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            used_ff <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         ctl_ff    <= ctl_in;
      end
      if (state_ff == S_GATHER) begin
         read_word_ff <= 64'(gather_word);
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_RESP);
   assign rsp_status      = status_ff;
   assign rsp_read_word   = read_word_ff;
   assign rsp_entry_count = 7'(used_ff);
   assign rsp_is_empty    = (used_ff == '0);
   assign rsp_is_full     = (used_ff == CNT_W'(CAPACITY));

   always_comb begin
      cell_ctl    = ctl_ff;
      if (state_ff != S_EXEC) begin
         cell_ctl.op = OP_NONE;
      end
   end

endmodule
